>>> rtl/pca_pkg.sv
// shared constants, codes and types of the paged cache page allocator
// no dependencies
package pca_pkg;

    localparam int ROWS              = 64;
    localparam int MAX_PAGES_PER_ROW = 32;
    localparam int NUM_PAGES         = 1024;

    localparam int KIND_W = 2;
    localparam int ROW_W  = 6;
    localparam int TOK_W  = 14;
    localparam int STAT_W = 2;
    localparam int PAGE_W = 10;
    localparam int TPP_W  = 9;

    localparam int TOK_MAX   = 16383;
    localparam int TPP_RESET = 16;
    localparam int TPP_MAX   = 256;

    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W    = (MAX_PAGES_PER_ROW > 1) ? $clog2(MAX_PAGES_PER_ROW) : 1;
    localparam int SLOT_CW   = $clog2(MAX_PAGES_PER_ROW + 1);
    localparam int MAP_DEPTH = ROWS * MAX_PAGES_PER_ROW;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int Q_AW      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int FC_W      = $clog2(NUM_PAGES + 1);
    localparam int SUM_W     = TOK_W + 1;
    localparam int DIV_W     = 16;
    localparam int DIV_CW    = $clog2(DIV_W);
    localparam int ROWM_W    = TOK_W + MAX_PAGES_PER_ROW;

    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXTEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_BUSY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_LIMIT = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOMEM = 2'd3;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } pca_div_rsp_t;

endpackage

>>> rtl/pca_if.sv
// request, response and configuration channel interfaces
// depends on pca_pkg
interface pca_req_if;
    logic                        valid;
    logic                        ready;
    logic [pca_pkg::KIND_W-1:0]  kind;
    logic [pca_pkg::ROW_W-1:0]   row;
    logic [pca_pkg::TOK_W-1:0]   tokens;
    modport source (output valid, kind, row, tokens, input ready);
    modport sink   (input valid, kind, row, tokens, output ready);
endinterface

interface pca_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pca_pkg::STAT_W-1:0]  status;
    logic                        page_valid;
    logic [pca_pkg::PAGE_W-1:0]  page_id;
    logic [pca_pkg::TOK_W-1:0]   row_tokens;
    logic                        last_result;
    modport source (output valid, status, page_valid, page_id, row_tokens, last_result,
                    input ready);
    modport sink   (input valid, status, page_valid, page_id, row_tokens, last_result,
                    output ready);
endinterface

interface pca_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pca_pkg::TPP_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/pca_ram.sv
// generic simple dual port ram, registered read
// no dependencies
module pca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/pca_div.sv
// restoring divider, one quotient bit per cycle
// depends on pca_pkg
module pca_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pca_pkg::DIV_W-1:0]   dividend,
    input  logic [pca_pkg::TPP_W-1:0]   divisor,
    output pca_pkg::pca_div_rsp_t       rsp
);
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [pca_pkg::DIV_CW-1:0]  cnt_reg, cnt_next;
    logic [pca_pkg::DIV_W-1:0]   dq_reg, dq_next;
    logic [pca_pkg::TPP_W:0]     rem_reg, rem_next;
    logic [pca_pkg::TPP_W-1:0]   dvs_reg, dvs_next;
    logic [pca_pkg::TPP_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg[pca_pkg::TPP_W-1:0], dq_reg[pca_pkg::DIV_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                dq_next  = {dq_reg[pca_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                dq_next  = {dq_reg[pca_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pca_pkg::DIV_CW'(pca_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dq_reg;
endmodule

>>> rtl/paged_cache_page_allocator.sv
// top level of the paged cache page allocator: request sequencer, free page
// queue, page map and row table memories; depends on pca_pkg, pca_if, pca_ram, pca_div
//
// channel  dir  transaction
// cfg      in   tokens_per_page write
// req      in   kind, row, tokens
// rsp      out  status, page_valid, page_id, row_tokens, last_result
//
// one request at a time: accept, row read, then round-up division (one for free, two
// for allocate and extend); allocate and extend then check and move each page with a
// queue read and an emit step, free moves each page with a map read and an emit step;
// busy, zero extend and empty free go from the row read straight to the emit step
// reset and clear need no queue memory init: queue contents track a fill count
// a stalled rsp holds the sequencer in its page take, page free or emit step

module paged_cache_page_allocator (
    input  logic         clk,
    input  logic         rst_n,
    pca_cfg_if.sink      cfg,
    pca_req_if.sink      req,
    pca_rsp_if.source    rsp
);
    localparam int MAXP = pca_pkg::MAX_PAGES_PER_ROW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ROW  = 4'd1;
    localparam logic [3:0] S_DA   = 4'd2;
    localparam logic [3:0] S_WA   = 4'd3;
    localparam logic [3:0] S_DB   = 4'd4;
    localparam logic [3:0] S_WB   = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_TRD  = 4'd7;
    localparam logic [3:0] S_TEM  = 4'd8;
    localparam logic [3:0] S_FRD  = 4'd9;
    localparam logic [3:0] S_FEM  = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;

    function automatic logic [MAXP-1:0] low_mask(input logic [pca_pkg::SLOT_CW-1:0] n);
        logic [MAXP-1:0] m;
        for (int j = 0; j < MAXP; j++)
        begin
            m[j] = (pca_pkg::SLOT_CW'(j) < n);
        end
        return m;
    endfunction

    function automatic logic [pca_pkg::SLOT_W-1:0] low_bit(input logic [MAXP-1:0] m);
        logic [pca_pkg::SLOT_W-1:0] idx;
        idx = '0;
        for (int j = MAXP - 1; j >= 0; j--)
        begin
            if (m[j])
            begin
                idx = pca_pkg::SLOT_W'(j);
            end
        end
        return idx;
    endfunction

    function automatic logic [pca_pkg::MAP_AW-1:0] map_addr(
        input logic [pca_pkg::ROW_W-1:0]   r,
        input logic [pca_pkg::SLOT_CW-1:0] s
    );
        return pca_pkg::MAP_AW'(r * MAXP + s);
    endfunction

    // control registers
    logic [3:0]                   state_reg, state_next;
    logic                         out_v_reg, out_v_next;
    logic [pca_pkg::TPP_W-1:0]    tpp_reg, tpp_next;
    logic [pca_pkg::Q_AW-1:0]     head_reg, head_next;
    logic [pca_pkg::Q_AW-1:0]     tail_reg, tail_next;
    logic [pca_pkg::FC_W-1:0]     free_count_reg, free_count_next;
    logic [pca_pkg::FC_W-1:0]     push_cnt_reg, push_cnt_next;
    logic [pca_pkg::ROWS-1:0]     row_valid_reg, row_valid_next;

    // payload registers
    logic [pca_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [pca_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [pca_pkg::TOK_W-1:0]    tok_reg, tok_next;
    logic [pca_pkg::TOK_W-1:0]    cur_reg, cur_next;
    logic [MAXP-1:0]              mask_reg, mask_next;
    logic [MAXP-1:0]              fmask_reg, fmask_next;
    logic [pca_pkg::TOK_W-1:0]    base_reg, base_next;
    logic [pca_pkg::SUM_W-1:0]    total_reg, total_next;
    logic [pca_pkg::DIV_W-1:0]    oldp_reg, oldp_next;
    logic [pca_pkg::DIV_W-1:0]    newp_reg, newp_next;
    logic [pca_pkg::SLOT_CW-1:0]  slot_reg, slot_next;
    logic [pca_pkg::STAT_W-1:0]   res_st_reg, res_st_next;
    logic [pca_pkg::TOK_W-1:0]    res_tok_reg, res_tok_next;
    logic [pca_pkg::STAT_W-1:0]   o_st_reg, o_st_next;
    logic                         o_pv_reg, o_pv_next;
    logic [pca_pkg::PAGE_W-1:0]   o_pid_reg, o_pid_next;
    logic [pca_pkg::TOK_W-1:0]    o_tok_reg, o_tok_next;
    logic                         o_last_reg, o_last_next;

    // memory and divider ports
    logic                         row_we, row_re;
    logic [pca_pkg::ROW_AW-1:0]   row_waddr, row_raddr;
    logic [pca_pkg::ROWM_W-1:0]   row_wdata, row_rdata;
    logic                         map_we, map_re;
    logic [pca_pkg::MAP_AW-1:0]   map_waddr, map_raddr;
    logic [pca_pkg::PAGE_W-1:0]   map_wdata, map_rdata;
    logic                         q_we, q_re;
    logic [pca_pkg::PAGE_W-1:0]   q_wdata, q_rdata;
    logic                         div_start;
    logic [pca_pkg::DIV_W-1:0]    div_dividend;
    logic [pca_pkg::TPP_W-1:0]    psize;
    pca_pkg::pca_div_rsp_t        div_rsp;

    logic                         out_free;
    logic [pca_pkg::TOK_W-1:0]    rd_tok;
    logic [MAXP-1:0]              rd_mask;
    logic [pca_pkg::PAGE_W-1:0]   q_page;
    logic [pca_pkg::SLOT_CW-1:0]  free_cnt;
    logic [MAXP-1:0]              slot_bit;
    logic [MAXP-1:0]              fm_rest;
    logic                         take_last;

    assign out_free = !out_v_reg || rsp.ready;
    assign psize = (tpp_reg == '0) ? pca_pkg::TPP_W'(1) :
                   (tpp_reg > pca_pkg::TPP_W'(pca_pkg::TPP_MAX)) ?
                   pca_pkg::TPP_W'(pca_pkg::TPP_MAX) : tpp_reg;
    assign rd_tok  = row_valid_reg[row_reg[pca_pkg::ROW_AW-1:0]] ?
                     row_rdata[pca_pkg::ROWM_W-1:MAXP] : '0;
    assign rd_mask = row_valid_reg[row_reg[pca_pkg::ROW_AW-1:0]] ?
                     row_rdata[MAXP-1:0] : '0;
    assign q_page  = (pca_pkg::FC_W'(head_reg) < push_cnt_reg) ? q_rdata :
                     pca_pkg::PAGE_W'(head_reg);
    assign free_cnt = (div_rsp.quot > pca_pkg::DIV_W'(MAXP)) ?
                      pca_pkg::SLOT_CW'(MAXP) : div_rsp.quot[pca_pkg::SLOT_CW-1:0];
    assign slot_bit  = MAXP'(1) << slot_reg[pca_pkg::SLOT_W-1:0];
    assign fm_rest   = fmask_reg & ~slot_bit;
    assign take_last = (pca_pkg::DIV_W'(slot_reg) + pca_pkg::DIV_W'(1)) == newp_reg;
    assign div_dividend = ((state_reg == S_DB) ? pca_pkg::DIV_W'(total_reg) :
                          pca_pkg::DIV_W'(base_reg)) + pca_pkg::DIV_W'(psize) -
                          pca_pkg::DIV_W'(1);

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        out_v_next      = out_v_reg;
        tpp_next        = tpp_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_count_next = free_count_reg;
        push_cnt_next   = push_cnt_reg;
        row_valid_next  = row_valid_reg;
        kind_next       = kind_reg;
        row_next        = row_reg;
        tok_next        = tok_reg;
        cur_next        = cur_reg;
        mask_next       = mask_reg;
        fmask_next      = fmask_reg;
        base_next       = base_reg;
        total_next      = total_reg;
        oldp_next       = oldp_reg;
        newp_next       = newp_reg;
        slot_next       = slot_reg;
        res_st_next     = res_st_reg;
        res_tok_next    = res_tok_reg;
        o_st_next       = o_st_reg;
        o_pv_next       = o_pv_reg;
        o_pid_next      = o_pid_reg;
        o_tok_next      = o_tok_reg;
        o_last_next     = o_last_reg;
        row_we          = 1'b0;
        row_waddr       = row_reg[pca_pkg::ROW_AW-1:0];
        row_wdata       = '0;
        row_re          = 1'b0;
        row_raddr       = req.row[pca_pkg::ROW_AW-1:0];
        map_we          = 1'b0;
        map_waddr       = map_addr(row_reg, slot_reg);
        map_wdata       = q_page;
        map_re          = 1'b0;
        map_raddr       = map_addr(row_reg, pca_pkg::SLOT_CW'(low_bit(fmask_reg)));
        q_we            = 1'b0;
        q_wdata         = map_rdata;
        q_re            = 1'b0;
        div_start       = 1'b0;

        if (cfg.valid)
        begin
            tpp_next = cfg.data;
        end
        if (out_v_reg && rsp.ready)
        begin
            out_v_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next = req.kind;
                    row_next  = req.row;
                    tok_next  = req.tokens;
                    if (req.kind == pca_pkg::KIND_CLEAR)
                    begin
                        head_next       = '0;
                        tail_next       = '0;
                        push_cnt_next   = '0;
                        free_count_next = pca_pkg::FC_W'(pca_pkg::NUM_PAGES);
                        row_valid_next  = '0;
                        res_st_next     = pca_pkg::ST_OK;
                        res_tok_next    = '0;
                        state_next      = S_EMIT;
                    end
                    else if ({1'b0, req.row} >= (pca_pkg::ROW_W + 1)'(pca_pkg::ROWS))
                    begin
                        res_st_next  = pca_pkg::ST_OK;
                        res_tok_next = '0;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        row_re     = 1'b1;
                        state_next = S_ROW;
                    end
                end
            end
            S_ROW:
            begin
                cur_next  = rd_tok;
                mask_next = rd_mask;
                base_next = (kind_reg == pca_pkg::KIND_ALLOC) ? '0 : rd_tok;
                total_next = ((kind_reg == pca_pkg::KIND_ALLOC) ? pca_pkg::SUM_W'(0) :
                             pca_pkg::SUM_W'(rd_tok)) + pca_pkg::SUM_W'(tok_reg);
                state_next = S_DA;
                if (kind_reg == pca_pkg::KIND_ALLOC && rd_tok != '0)
                begin
                    res_st_next  = pca_pkg::ST_BUSY;
                    res_tok_next = rd_tok;
                    state_next   = S_EMIT;
                end
                else if (kind_reg == pca_pkg::KIND_EXTEND && tok_reg == '0)
                begin
                    res_st_next  = pca_pkg::ST_OK;
                    res_tok_next = rd_tok;
                    state_next   = S_EMIT;
                end
                else if (kind_reg == pca_pkg::KIND_FREE && rd_tok == '0)
                begin
                    res_st_next  = pca_pkg::ST_OK;
                    res_tok_next = '0;
                    state_next   = S_EMIT;
                end
            end
            S_DA:
            begin
                div_start  = 1'b1;
                state_next = S_WA;
            end
            S_WA:
            begin
                if (div_rsp.done)
                begin
                    oldp_next = div_rsp.quot;
                    if (kind_reg == pca_pkg::KIND_FREE)
                    begin
                        fmask_next = mask_reg & low_mask(free_cnt);
                        if ((mask_reg & low_mask(free_cnt)) == '0)
                        begin
                            row_we       = 1'b1;
                            row_wdata    = '0;
                            res_st_next  = pca_pkg::ST_OK;
                            res_tok_next = '0;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_FRD;
                        end
                    end
                    else
                    begin
                        state_next = S_DB;
                    end
                end
            end
            S_DB:
            begin
                div_start  = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                if (div_rsp.done)
                begin
                    newp_next  = div_rsp.quot;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                slot_next = oldp_reg[pca_pkg::SLOT_CW-1:0];
                if (total_reg > pca_pkg::SUM_W'(pca_pkg::TOK_MAX) ||
                    newp_reg > pca_pkg::DIV_W'(MAXP))
                begin
                    res_st_next  = pca_pkg::ST_LIMIT;
                    res_tok_next = cur_reg;
                    state_next   = S_EMIT;
                end
                else if (newp_reg > oldp_reg &&
                         {1'b0, pca_pkg::DIV_W'(free_count_reg)} <
                         {1'b0, newp_reg - oldp_reg})
                begin
                    res_st_next  = pca_pkg::ST_NOMEM;
                    res_tok_next = cur_reg;
                    state_next   = S_EMIT;
                end
                else if (newp_reg > oldp_reg)
                begin
                    state_next = S_TRD;
                end
                else
                begin
                    row_we       = 1'b1;
                    row_wdata    = {total_reg[pca_pkg::TOK_W-1:0], mask_reg};
                    res_st_next  = pca_pkg::ST_OK;
                    res_tok_next = total_reg[pca_pkg::TOK_W-1:0];
                    state_next   = S_EMIT;
                end
            end
            S_TRD:
            begin
                q_re       = 1'b1;
                state_next = S_TEM;
            end
            S_TEM:
            begin
                if (out_free)
                begin
                    out_v_next      = 1'b1;
                    o_st_next       = pca_pkg::ST_OK;
                    o_pv_next       = 1'b1;
                    o_pid_next      = q_page;
                    o_tok_next      = total_reg[pca_pkg::TOK_W-1:0];
                    o_last_next     = take_last;
                    map_we          = 1'b1;
                    mask_next       = mask_reg | slot_bit;
                    head_next       = (head_reg == pca_pkg::Q_AW'(pca_pkg::NUM_PAGES - 1)) ?
                                      '0 : head_reg + 1'b1;
                    free_count_next = free_count_reg - 1'b1;
                    slot_next       = slot_reg + 1'b1;
                    if (take_last)
                    begin
                        row_we     = 1'b1;
                        row_wdata  = {total_reg[pca_pkg::TOK_W-1:0], mask_reg | slot_bit};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_TRD;
                    end
                end
            end
            S_FRD:
            begin
                map_re     = 1'b1;
                slot_next  = pca_pkg::SLOT_CW'(low_bit(fmask_reg));
                state_next = S_FEM;
            end
            S_FEM:
            begin
                if (out_free)
                begin
                    out_v_next  = 1'b1;
                    o_st_next   = pca_pkg::ST_OK;
                    o_pv_next   = 1'b1;
                    o_pid_next  = map_rdata;
                    o_tok_next  = '0;
                    o_last_next = (fm_rest == '0);
                    fmask_next  = fm_rest;
                    if (free_count_reg < pca_pkg::FC_W'(pca_pkg::NUM_PAGES))
                    begin
                        q_we            = 1'b1;
                        tail_next       = (tail_reg == pca_pkg::Q_AW'(pca_pkg::NUM_PAGES - 1)) ?
                                          '0 : tail_reg + 1'b1;
                        free_count_next = free_count_reg + 1'b1;
                        if (push_cnt_reg < pca_pkg::FC_W'(pca_pkg::NUM_PAGES))
                        begin
                            push_cnt_next = push_cnt_reg + 1'b1;
                        end
                    end
                    if (fm_rest == '0)
                    begin
                        row_we     = 1'b1;
                        row_wdata  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FRD;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_v_next  = 1'b1;
                    o_st_next   = res_st_reg;
                    o_pv_next   = 1'b0;
                    o_pid_next  = '0;
                    o_tok_next  = res_tok_reg;
                    o_last_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (row_we)
        begin
            row_valid_next[row_reg[pca_pkg::ROW_AW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_v_reg      <= 1'b0;
            tpp_reg        <= pca_pkg::TPP_W'(pca_pkg::TPP_RESET);
            head_reg       <= '0;
            tail_reg       <= '0;
            free_count_reg <= pca_pkg::FC_W'(pca_pkg::NUM_PAGES);
            push_cnt_reg   <= '0;
            row_valid_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_v_reg      <= out_v_next;
            tpp_reg        <= tpp_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_count_reg <= free_count_next;
            push_cnt_reg   <= push_cnt_next;
            row_valid_reg  <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        row_reg     <= row_next;
        tok_reg     <= tok_next;
        cur_reg     <= cur_next;
        mask_reg    <= mask_next;
        fmask_reg   <= fmask_next;
        base_reg    <= base_next;
        total_reg   <= total_next;
        oldp_reg    <= oldp_next;
        newp_reg    <= newp_next;
        slot_reg    <= slot_next;
        res_st_reg  <= res_st_next;
        res_tok_reg <= res_tok_next;
        o_st_reg    <= o_st_next;
        o_pv_reg    <= o_pv_next;
        o_pid_reg   <= o_pid_next;
        o_tok_reg   <= o_tok_next;
        o_last_reg  <= o_last_next;
    end

    assign rsp.valid       = out_v_reg;
    assign rsp.status      = o_st_reg;
    assign rsp.page_valid  = o_pv_reg;
    assign rsp.page_id     = o_pid_reg;
    assign rsp.row_tokens  = o_tok_reg;
    assign rsp.last_result = o_last_reg;

    pca_ram #(.WIDTH(pca_pkg::ROWM_W), .DEPTH(pca_pkg::ROWS)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    pca_ram #(.WIDTH(pca_pkg::PAGE_W), .DEPTH(pca_pkg::MAP_DEPTH)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    pca_ram #(.WIDTH(pca_pkg::PAGE_W), .DEPTH(pca_pkg::NUM_PAGES)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    pca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (psize),
        .rsp      (div_rsp)
    );

    a_free_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= pca_pkg::FC_W'(pca_pkg::NUM_PAGES))
        else $error("free page count above pool size");

    a_take_has_page: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TEM |-> free_count_reg != '0)
        else $error("page taken from empty queue");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_WA || state_reg == S_WB))
        else $error("divider result outside a wait step");

    a_page_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.page_valid |-> rsp.status == pca_pkg::ST_OK)
        else $error("moved page carries an error status");
endmodule

>>> verif/paged_cache_page_allocator_test.sv
// testbench for paged_cache_page_allocator: random and directed requests, a page
// allocation predictor in a scoreboard class, random idling on both channels
// depends on pca_pkg and the pca_if interfaces
module paged_cache_page_allocator_test;

    typedef struct {
        logic [pca_pkg::STAT_W-1:0] status;
        logic                       page_valid;
        logic [pca_pkg::PAGE_W-1:0] page_id;
        logic [pca_pkg::TOK_W-1:0]  row_tokens;
        logic                       last_result;
    } page_result_t;

    class page_alloc_scoreboard;
        int unsigned            page_size_reg;
        int unsigned            free_fifo[pca_pkg::NUM_PAGES];
        int unsigned            fifo_head;
        int unsigned            fifo_tail;
        int unsigned            fifo_count;
        int unsigned            row_pages[pca_pkg::ROWS][pca_pkg::MAX_PAGES_PER_ROW];
        bit [pca_pkg::MAX_PAGES_PER_ROW-1:0] slot_used[pca_pkg::ROWS];
        int unsigned            row_count[pca_pkg::ROWS];
        page_result_t           expected_results[$];
        int                     mismatches;

        function void clear_all();
            for (int i = 0; i < pca_pkg::NUM_PAGES; i++)
                free_fifo[i] = i;
            fifo_head = 0;
            fifo_tail = 0;
            fifo_count = pca_pkg::NUM_PAGES;
            for (int r = 0; r < pca_pkg::ROWS; r++)
            begin
                slot_used[r] = '0;
                row_count[r] = 0;
            end
        endfunction

        function void power_up();
            page_size_reg = pca_pkg::TPP_RESET;
            mismatches = 0;
            clear_all();
        endfunction

        function int unsigned eff_size();
            if (page_size_reg == 0)
                return 1;
            if (page_size_reg > pca_pkg::TPP_MAX)
                return pca_pkg::TPP_MAX;
            return page_size_reg;
        endfunction

        function int unsigned pages_needed(int unsigned tokens);
            return (tokens + eff_size() - 1) / eff_size();
        endfunction

        function void add_result(logic [pca_pkg::STAT_W-1:0] st, logic pv, int unsigned id,
                                 int unsigned tokens);
            page_result_t e;
            e.status = st;
            e.page_valid = pv;
            e.page_id = id[pca_pkg::PAGE_W-1:0];
            e.row_tokens = tokens[pca_pkg::TOK_W-1:0];
            e.last_result = 1'b0;
            expected_results.insert(expected_results.size(), e);
        endfunction

        function int take_pages(int unsigned r, int unsigned first, int unsigned last_slot,
                                int unsigned tokens);
            int n;
            int unsigned p;
            n = 0;
            for (int unsigned i = first; i < last_slot; i++)
            begin
                p = free_fifo[fifo_head];
                fifo_head = (fifo_head + 1) % pca_pkg::NUM_PAGES;
                fifo_count--;
                row_pages[r][i] = p;
                slot_used[r][i] = 1'b1;
                add_result(pca_pkg::ST_OK, 1'b1, p, tokens);
                n++;
            end
            return n;
        endfunction

        function void note_request(logic [pca_pkg::KIND_W-1:0] kind, int unsigned r,
                                   int unsigned t);
            int n;
            int unsigned cur, total, oldp, newp, cnt, p;
            n = 0;
            cur = row_count[r];
            if (kind == pca_pkg::KIND_CLEAR)
            begin
                clear_all();
                add_result(pca_pkg::ST_OK, 1'b0, 0, 0);
                n = 1;
            end
            else if (kind == pca_pkg::KIND_ALLOC)
            begin
                newp = pages_needed(t);
                if (cur != 0)
                    add_result(pca_pkg::ST_BUSY, 1'b0, 0, cur);
                else if (newp > pca_pkg::MAX_PAGES_PER_ROW)
                    add_result(pca_pkg::ST_LIMIT, 1'b0, 0, cur);
                else if (fifo_count < newp)
                    add_result(pca_pkg::ST_NOMEM, 1'b0, 0, cur);
                else
                begin
                    n = take_pages(r, 0, newp, t);
                    row_count[r] = t;
                    if (n == 0)
                        add_result(pca_pkg::ST_OK, 1'b0, 0, t);
                end
            end
            else if (kind == pca_pkg::KIND_EXTEND)
            begin
                total = cur + t;
                oldp = pages_needed(cur);
                newp = pages_needed(total);
                if (t == 0)
                    add_result(pca_pkg::ST_OK, 1'b0, 0, cur);
                else if (total > pca_pkg::TOK_MAX || newp > pca_pkg::MAX_PAGES_PER_ROW)
                    add_result(pca_pkg::ST_LIMIT, 1'b0, 0, cur);
                else if (newp > oldp && fifo_count < newp - oldp)
                    add_result(pca_pkg::ST_NOMEM, 1'b0, 0, cur);
                else
                begin
                    if (newp > oldp)
                        n = take_pages(r, oldp, newp, total);
                    row_count[r] = total;
                    if (n == 0)
                        add_result(pca_pkg::ST_OK, 1'b0, 0, total);
                end
            end
            else
            begin
                if (cur != 0)
                begin
                    cnt = pages_needed(cur);
                    if (cnt > pca_pkg::MAX_PAGES_PER_ROW)
                        cnt = pca_pkg::MAX_PAGES_PER_ROW;
                    for (int unsigned i = 0; i < cnt; i++)
                    begin
                        if (slot_used[r][i])
                        begin
                            p = row_pages[r][i];
                            if (fifo_count < pca_pkg::NUM_PAGES)
                            begin
                                free_fifo[fifo_tail] = p;
                                fifo_tail = (fifo_tail + 1) % pca_pkg::NUM_PAGES;
                                fifo_count++;
                            end
                            add_result(pca_pkg::ST_OK, 1'b1, p, 0);
                            n++;
                        end
                    end
                    slot_used[r] = '0;
                    row_count[r] = 0;
                end
                if (n == 0)
                    add_result(pca_pkg::ST_OK, 1'b0, 0, 0);
            end
            expected_results[expected_results.size()-1].last_result = 1'b1;
        endfunction

        function void check_result(page_result_t got);
            page_result_t e;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response transaction: status %0d page %0d/%0d",
                             got.status, got.page_valid, got.page_id);
                return;
            end
            e = expected_results[0];
            expected_results.delete(0);
            if (got.status !== e.status || got.page_valid !== e.page_valid ||
                got.page_id !== e.page_id || got.row_tokens !== e.row_tokens ||
                got.last_result !== e.last_result)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected st %0d pv %0d id %0d tok %0d last %0d",
                             e.status, e.page_valid, e.page_id, e.row_tokens, e.last_result);
                    $display("          got      st %0d pv %0d id %0d tok %0d last %0d",
                             got.status, got.page_valid, got.page_id, got.row_tokens,
                             got.last_result);
                end
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 150;

    logic clk;
    logic rst_n;
    pca_cfg_if cfg_ch ();
    pca_req_if req_ch ();
    pca_rsp_if rsp_ch ();

    paged_cache_page_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch.sink),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    page_alloc_scoreboard sb;
    bit send_gaps;
    bit recv_stalls;
    int hold_cycles;
    int stall_left;
    int cycle_count;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        page_result_t got;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.page_size_reg = cfg_ch.data;
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.kind, req_ch.row, req_ch.tokens);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = rsp_ch.status;
                got.page_valid = rsp_ch.page_valid;
                got.page_id = rsp_ch.page_id;
                got.row_tokens = rsp_ch.row_tokens;
                got.last_result = rsp_ch.last_result;
                sb.check_result(got);
            end
        end
    end

    // response side readiness: long hold-off, random stall bursts
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (recv_stalls && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    task automatic write_page_size(input int unsigned value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value[pca_pkg::TPP_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // leaves the bus at a falling edge; valid stays up for a following item unless a random gap drops it
    task automatic send_request(input logic [pca_pkg::KIND_W-1:0] kind, input int unsigned r,
                                input int unsigned t);
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.row <= r[pca_pkg::ROW_W-1:0];
        req_ch.tokens <= t[pca_pkg::TOK_W-1:0];
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int unsigned pick_tokens();
        int unsigned span;
        span = sb.eff_size() * (pca_pkg::MAX_PAGES_PER_ROW + 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(1, span < 16383 ? span : 16383);
            6:       return $urandom_range(0, 8192);
            7:       return $urandom_range(0, 16383);
            8:       return $urandom_range(0, 1) ? 16383 : 8192;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    task automatic random_requests(input int count);
        int unsigned w;
        logic [pca_pkg::KIND_W-1:0] kind;
        for (int i = 0; i < count; i++)
        begin
            w = $urandom_range(0, 99);
            if (w < 38)
                kind = pca_pkg::KIND_ALLOC;
            else if (w < 68)
                kind = pca_pkg::KIND_EXTEND;
            else if (w < 97)
                kind = pca_pkg::KIND_FREE;
            else
                kind = pca_pkg::KIND_CLEAR;
            send_request(kind, $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63),
                         pick_tokens());
        end
    endtask

    initial
    begin
        sb = new();
        sb.power_up();
        rst_n = 1'b0;
        cycle_count = 0;
        hold_cycles = 0;
        stall_left = 0;
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.kind = pca_pkg::KIND_ALLOC;
        req_ch.row = '0;
        req_ch.tokens = '0;
        rsp_ch.ready = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset page size
        send_request(pca_pkg::KIND_ALLOC, 0, 0);
        send_request(pca_pkg::KIND_ALLOC, 1, 1);
        send_request(pca_pkg::KIND_ALLOC, 1, 5);
        send_request(pca_pkg::KIND_ALLOC, 2, 513);
        send_request(pca_pkg::KIND_ALLOC, 2, 512);
        send_request(pca_pkg::KIND_EXTEND, 2, 0);
        send_request(pca_pkg::KIND_EXTEND, 2, 1);
        send_request(pca_pkg::KIND_EXTEND, 3, 17);
        send_request(pca_pkg::KIND_EXTEND, 3, 15);
        send_request(pca_pkg::KIND_EXTEND, 3, 16383);
        send_request(pca_pkg::KIND_FREE, 3, 0);
        send_request(pca_pkg::KIND_FREE, 3, 0);
        send_request(pca_pkg::KIND_ALLOC, 63, 16383);
        send_request(pca_pkg::KIND_ALLOC, 63, 100);
        send_request(pca_pkg::KIND_FREE, 2, 16383);
        send_request(pca_pkg::KIND_CLEAR, 63, 16383);
        send_request(pca_pkg::KIND_FREE, 63, 0);
        wait_idle();

        // exhaust the free queue, then overrun it
        for (int r = 0; r < 33; r++)
            send_request(pca_pkg::KIND_ALLOC, r, 512);
        send_request(pca_pkg::KIND_EXTEND, 40, 1);
        send_request(pca_pkg::KIND_FREE, 5, 0);
        send_request(pca_pkg::KIND_ALLOC, 40, 512);
        wait_idle();

        // page size changes with rows still holding pages
        write_page_size(1);
        random_requests(70);
        hold_cycles = 400;
        random_requests(20);
        wait_idle();
        write_page_size(256);
        random_requests(70);
        wait_idle();
        write_page_size(0);
        random_requests(60);
        wait_idle();
        write_page_size(511);
        random_requests(60);
        wait_idle();
        write_page_size($urandom_range(2, 40));
        send_request(pca_pkg::KIND_CLEAR, 0, 0);
        random_requests(70);
        wait_idle();
        write_page_size($urandom_range(0, 511));
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        random_requests(50);
        wait_idle();

        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

>>> paged_cache_page_allocator.f
rtl/pca_pkg.sv
rtl/pca_if.sv
rtl/pca_ram.sv
rtl/pca_div.sv
rtl/paged_cache_page_allocator.sv
verif/paged_cache_page_allocator_test.sv
